// ===== rtl/gft_pkg.sv =====
`timescale 1ns / 1ps
package gft_pkg;

    localparam int LEN_W     = 24;
    localparam int PHASE_W   = 16;
    localparam int TIME_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_STEPS = 16;

    localparam logic signed [LEN_W-1:0] DEADBAND = 24'sd100;
    localparam logic signed [LEN_W-1:0] LEN_MAX  = 24'sh7FFFFF;
    localparam logic signed [LEN_W-1:0] LEN_MIN  = 24'sh800000;

    typedef enum logic [1:0] {
        MODE_STAND = 2'd0,
        MODE_TROT  = 2'd1,
        MODE_CRAWL = 2'd2,
        MODE_RSVD  = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOME_X      = 3'd0,
        CFG_HOME_Y      = 3'd1,
        CFG_HOME_Z      = 3'd2,
        CFG_LIMB_OFS    = 3'd3,
        CFG_CRAWL_OFS   = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_HOME   = 2'd0,
        KIND_STANCE = 2'd1,
        KIND_SWING  = 2'd2
    } kind_t;

endpackage

// ===== rtl/gait_foot_trajectory_core.sv =====
`timescale 1ns / 1ps
// foot trajectory core: one foot target word per input word
// input channel s_*: gait mode, global phase, stride, lift and durations;
// accepted when s_valid and s_ready are both high
// result channel m_*: foot_x/y/z, saturated signed micrometres
// config port: cfg_wr_en writes cfg_wdata into register cfg_index
// (0 home_x, 1 home_y, 2 home_z, 3 limb_offset, 4 crawl_limb_offset);
// write only while the pipeline is empty
// the front register loads at the accepting edge, followed by the 16-stage
// restoring divider (one quotient bit per stage), four post stages and the
// output register
// throughput: one word per cycle while the output is not stalled; all stages advance together
// reset (aresetn low, synchronous) clears all valid bits and the config registers, not the data registers
// when m_ready is low with m_valid high the whole pipeline holds and
// s_ready drops; nothing is lost or repeated
module gait_foot_trajectory_core
    import gft_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [LEN_W-1:0]         cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_mode,
    input  logic [PHASE_W-1:0]       s_cycle_phase,
    input  logic signed [LEN_W-1:0]  s_stride_x,
    input  logic signed [LEN_W-1:0]  s_stride_y,
    input  logic signed [LEN_W-1:0]  s_lift_height,
    input  logic [TIME_W-1:0]        s_stance_time,
    input  logic [TIME_W-1:0]        s_swing_time,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [LEN_W-1:0]  m_foot_x,
    output logic signed [LEN_W-1:0]  m_foot_y,
    output logic signed [LEN_W-1:0]  m_foot_z
);

    logic signed [LEN_W-1:0] home_x_reg, home_y_reg, home_z_reg;
    logic [PHASE_W-1:0]      limb_ofs_reg, crawl_ofs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            home_x_reg    <= '0;
            home_y_reg    <= '0;
            home_z_reg    <= '0;
            limb_ofs_reg  <= '0;
            crawl_ofs_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_HOME_X:    home_x_reg    <= cfg_wdata;
                CFG_HOME_Y:    home_y_reg    <= cfg_wdata;
                CFG_HOME_Z:    home_z_reg    <= cfg_wdata;
                CFG_LIMB_OFS:  limb_ofs_reg  <= cfg_wdata[PHASE_W-1:0];
                CFG_CRAWL_OFS: crawl_ofs_reg <= cfg_wdata[PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    logic adv;
    logic out_valid_reg;
    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    // front: limb phase, stance/swing decision, divider operands
    logic [PHASE_W-1:0]  phase;
    logic [TIME_W:0]     dur_sum;
    logic [32:0]         lhs;
    logic [31:0]         rhs;
    logic                active, dead;
    kind_t               kind_next;
    logic [31:0]         num_next;
    logic [TIME_W-1:0]   den_next;

    always_comb begin
        phase   = s_cycle_phase + ((s_mode == MODE_CRAWL) ? crawl_ofs_reg : limb_ofs_reg);
        dur_sum = {1'b0, s_stance_time} + {1'b0, s_swing_time};
        lhs     = {16'b0, phase} * {16'b0, dur_sum};
        rhs     = {s_stance_time, 16'b0};
        active  = (s_mode == MODE_TROT) || (s_mode == MODE_CRAWL);
        dead    = (s_stride_x > -DEADBAND) && (s_stride_x < DEADBAND)
               && (s_stride_y > -DEADBAND) && (s_stride_y < DEADBAND);
        kind_next = KIND_HOME;
        num_next  = '0;
        den_next  = 16'd1;
        if (active && !dead && dur_sum != '0) begin
            if (lhs < {1'b0, rhs}) begin
                kind_next = KIND_STANCE;
                num_next  = lhs[31:0];
                den_next  = s_stance_time;
            end else if (s_swing_time != '0) begin
                kind_next = KIND_SWING;
                num_next  = lhs[31:0] - rhs;
                den_next  = s_swing_time;
            end
        end
    end

    // divider pipeline, one quotient bit per stage
    logic                    v_reg    [0:DIV_STEPS];
    kind_t                   kind_reg [0:DIV_STEPS];
    logic [31:0]             rem_reg  [0:DIV_STEPS];
    logic [TIME_W-1:0]       den_reg  [0:DIV_STEPS];
    logic [15:0]             q_reg    [0:DIV_STEPS];
    logic signed [LEN_W-1:0] sx_reg   [0:DIV_STEPS];
    logic signed [LEN_W-1:0] sy_reg   [0:DIV_STEPS];
    logic signed [LEN_W-1:0] lf_reg   [0:DIV_STEPS];

    logic [31:0] rem_next [0:DIV_STEPS-1];
    logic [15:0] q_next   [0:DIV_STEPS-1];

    always_comb begin
        logic [32:0] trial;
        for (int j = 0; j < DIV_STEPS; j++) begin
            trial       = {1'b0, rem_reg[j]} - ({17'b0, den_reg[j]} << (DIV_STEPS - 1 - j));
            rem_next[j] = rem_reg[j];
            q_next[j]   = q_reg[j];
            if (!trial[32]) begin
                rem_next[j] = trial[31:0];
                q_next[j][DIV_STEPS-1-j] = 1'b1;
            end
        end
    end

    // post stages
    logic               p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg;
    kind_t              p1_kind_reg, p2_kind_reg;
    logic [15:0]        p1_tq_reg;
    logic [31:0]        p1_t2_reg, p2_t2_reg;
    logic [33:0]        p1_b32_reg, p2_b32_reg;
    logic [16:0]        p1_rem_reg, p2_rem_reg;
    logic [47:0]        p2_t3_reg;
    logic [16:0]        p3_f_reg, p3_h_reg;
    logic signed [LEN_W-1:0] p1_sx_reg, p1_sy_reg, p1_lf_reg;
    logic signed [LEN_W-1:0] p2_sx_reg, p2_sy_reg, p2_lf_reg;
    logic signed [LEN_W-1:0] p3_sx_reg, p3_sy_reg, p3_lf_reg;
    logic signed [41:0] p4_px_reg, p4_py_reg, p4_pz_reg;

    logic [15:0] tq_last;
    logic [16:0] tq_rem;
    assign tq_last = q_reg[DIV_STEPS];
    assign tq_rem  = 17'h10000 - {1'b0, tq_last};

    logic [49:0] s48;
    logic [49:0] s_round;
    logic [33:0] h_round;
    logic [16:0] f_sel, h_sel;

    always_comb begin
        s48     = {p2_t2_reg, 16'b0, 2'b0} - {2'b0, p2_t2_reg, 16'b0}
                - {1'b0, p2_t3_reg, 1'b0};
        s_round = s48 + 50'h0_8000_0000;
        h_round = p2_b32_reg + 34'd32768;
        case (p2_kind_reg)
            KIND_STANCE: begin
                f_sel = p2_rem_reg;
                h_sel = '0;
            end
            KIND_SWING: begin
                f_sel = s_round[48:32];
                h_sel = h_round[32:16];
            end
            default: begin
                f_sel = '0;
                h_sel = '0;
            end
        endcase
    end

    function automatic logic signed [LEN_W-1:0] place(
        input logic signed [LEN_W-1:0] home,
        input logic signed [41:0]      prod
    );
        logic signed [41:0] rnd;
        logic signed [26:0] sum;
        begin
            rnd = (prod + 42'sd32768) >>> 16;
            sum = 27'(home) + rnd[26:0];
            if (sum > 27'(LEN_MAX))
                place = LEN_MAX;
            else if (sum < 27'(LEN_MIN))
                place = LEN_MIN;
            else
                place = sum[LEN_W-1:0];
        end
    endfunction

    logic signed [LEN_W-1:0] fx_reg, fy_reg, fz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= DIV_STEPS; j++)
                v_reg[j] <= 1'b0;
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            p3_v_reg      <= 1'b0;
            p4_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= s_valid;
            for (int j = 0; j < DIV_STEPS; j++)
                v_reg[j+1] <= v_reg[j];
            p1_v_reg      <= v_reg[DIV_STEPS];
            p2_v_reg      <= p1_v_reg;
            p3_v_reg      <= p2_v_reg;
            p4_v_reg      <= p3_v_reg;
            out_valid_reg <= p4_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            kind_reg[0] <= kind_next;
            rem_reg[0]  <= num_next;
            den_reg[0]  <= den_next;
            q_reg[0]    <= '0;
            sx_reg[0]   <= s_stride_x;
            sy_reg[0]   <= s_stride_y;
            lf_reg[0]   <= s_lift_height;
            for (int j = 0; j < DIV_STEPS; j++) begin
                kind_reg[j+1] <= kind_reg[j];
                rem_reg[j+1]  <= rem_next[j];
                den_reg[j+1]  <= den_reg[j];
                q_reg[j+1]    <= q_next[j];
                sx_reg[j+1]   <= sx_reg[j];
                sy_reg[j+1]   <= sy_reg[j];
                lf_reg[j+1]   <= lf_reg[j];
            end
            p1_kind_reg <= kind_reg[DIV_STEPS];
            p1_tq_reg   <= tq_last;
            p1_t2_reg   <= {16'b0, tq_last} * {16'b0, tq_last};
            p1_b32_reg  <= {18'b0, tq_last} * {17'b0, tq_rem} * 34'd3;
            p1_rem_reg  <= tq_rem;
            p1_sx_reg   <= sx_reg[DIV_STEPS];
            p1_sy_reg   <= sy_reg[DIV_STEPS];
            p1_lf_reg   <= lf_reg[DIV_STEPS];

            p2_kind_reg <= p1_kind_reg;
            p2_t2_reg   <= p1_t2_reg;
            p2_t3_reg   <= {16'b0, p1_t2_reg} * {32'b0, p1_tq_reg};
            p2_b32_reg  <= p1_b32_reg;
            p2_rem_reg  <= p1_rem_reg;
            p2_sx_reg   <= p1_sx_reg;
            p2_sy_reg   <= p1_sy_reg;
            p2_lf_reg   <= p1_lf_reg;

            p3_f_reg    <= f_sel;
            p3_h_reg    <= h_sel;
            p3_sx_reg   <= p2_sx_reg;
            p3_sy_reg   <= p2_sy_reg;
            p3_lf_reg   <= p2_lf_reg;

            p4_px_reg <= 42'(p3_sx_reg) * 42'($signed({1'b0, p3_f_reg}));
            p4_py_reg <= 42'(p3_sy_reg) * 42'($signed({1'b0, p3_f_reg}));
            p4_pz_reg <= 42'(p3_lf_reg) * 42'($signed({1'b0, p3_h_reg}));

            fx_reg <= place(home_x_reg, p4_px_reg);
            fy_reg <= place(home_y_reg, p4_py_reg);
            fz_reg <= place(home_z_reg, p4_pz_reg);
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_foot_x = fx_reg;
    assign m_foot_y = fy_reg;
    assign m_foot_z = fz_reg;

endmodule

// ===== rtl/gft_checker.sv =====
`timescale 1ns / 1ps
module gft_checker
    import gft_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_ready,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic signed [LEN_W-1:0] m_foot_x
);

    // result valid and foot_x hold while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_foot_x))
        else $error("result word dropped or changed under stall");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_stall_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

endmodule

bind gait_foot_trajectory_core gft_checker u_gft_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_foot_x (m_foot_x)
);

// ===== tb/sv/gait_foot_trajectory_core_tb.sv =====
`timescale 1ns / 1ps
module gait_foot_trajectory_core_tb;
    import gft_pkg::*;

    typedef struct packed {
        logic [1:0]         mode;
        logic [15:0]        phase;
        logic signed [23:0] sx;
        logic signed [23:0] sy;
        logic signed [23:0] lift;
        logic [15:0]        st;
        logic [15:0]        sw;
    } step_t;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
    } foot_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LEN_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_mode = '0;
    logic [15:0] s_cycle_phase = '0;
    logic signed [23:0] s_stride_x = '0, s_stride_y = '0, s_lift_height = '0;
    logic [15:0] s_stance_time = '0, s_swing_time = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [23:0] m_foot_x, m_foot_y, m_foot_z;

    logic signed [23:0] home_x = 0, home_y = 0, home_z = 0;
    logic [15:0] trot_ofs = 0, crawl_ofs = 0;

    foot_t expected_feet[$];
    int mismatches = 0;
    int words_checked = 0;
    int words_sent = 0;
    bit hold_sink = 1'b0;

    gait_foot_trajectory_core dut (.*);

    always #1 aclk = ~aclk;

    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint rnd16(longint v);
        longint a;
        longint q;
        a = v + 32768;
        q = a / 65536;
        if (a % 65536 != 0 && a < 0) q--;
        return q;
    endfunction

    function automatic logic signed [23:0] clamp24(longint v);
        if (v > 8388607) return 24'sh7FFFFF;
        if (v < -8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    function automatic foot_t foot_target(step_t w);
        longint fx, fy, fz, sx, sy, lf;
        longint unsigned p, lhs, rhs, tq, s48, b32;
        longint sm, hb;
        foot_t r;
        fx = home_x; fy = home_y; fz = home_z;
        sx = w.sx; sy = w.sy; lf = w.lift;
        if ((w.mode == MODE_TROT || w.mode == MODE_CRAWL)
                && !(sx > -100 && sx < 100 && sy > -100 && sy < 100)
                && (w.st + w.sw) != 0) begin
            p = (w.phase + ((w.mode == MODE_CRAWL) ? crawl_ofs : trot_ofs)) & 16'hFFFF;
            lhs = p * (longint'(w.st) + w.sw);
            rhs = longint'(w.st) << 16;
            if (lhs < rhs) begin
                tq = lhs / w.st;
                if (tq > 65536) tq = 65536;
                fx += rnd16(sx * longint'(65536 - tq));
                fy += rnd16(sy * longint'(65536 - tq));
            end else if (w.sw != 0) begin
                tq = (lhs - rhs) / w.sw;
                if (tq > 65536) tq = 65536;
                s48 = 3 * tq * tq * 65536 - 2 * tq * tq * tq;
                sm = longint'((s48 + 64'h80000000) >> 32);
                b32 = 3 * tq * (65536 - tq);
                hb = longint'((b32 + 32768) >> 16);
                fx += rnd16(sx * sm);
                fy += rnd16(sy * sm);
                fz += rnd16(lf * hb);
            end
        end
        r.x = clamp24(fx); r.y = clamp24(fy); r.z = clamp24(fz);
        return r;
    endfunction

    // result side: random stalls, compare against oldest expectation
    always @(posedge aclk) begin
        foot_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_feet.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %h %h %h",
                        m_foot_x, m_foot_y, m_foot_z);
                end else begin
                    e = expected_feet.pop_front();
                    words_checked++;
                    if (e.x !== m_foot_x || e.y !== m_foot_y || e.z !== m_foot_z) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp %0d %0d %0d got %0d %0d %0d",
                                e.x, e.y, e.z, m_foot_x, m_foot_y, m_foot_z);
                    end
                end
            end
            m_ready <= hold_sink ? 1'b1 : ($urandom_range(0, 4) == 0 ? 1'b0 : 1'b1);
        end
    end

    task automatic send_word(step_t w, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= w.mode; s_cycle_phase <= w.phase;
        s_stride_x <= w.sx; s_stride_y <= w.sy; s_lift_height <= w.lift;
        s_stance_time <= w.st; s_swing_time <= w.sw;
        expected_feet.push_back(foot_target(w));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_feet.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [23:0] v);
        cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_HOME_X: home_x = v;
            CFG_HOME_Y: home_y = v;
            CFG_HOME_Z: home_z = v;
            CFG_LIMB_OFS: trot_ofs = v[15:0];
            CFG_CRAWL_OFS: crawl_ofs = v[15:0];
            default: ;
        endcase
    endtask

    function automatic step_t random_step();
        step_t w;
        w.mode = $urandom_range(0, 9) == 0 ? 2'($urandom_range(0, 3))
                                           : 2'($urandom_range(1, 2));
        w.phase = 16'($urandom);
        case ($urandom_range(0, 3))
            0: begin w.sx = 24'($urandom); w.sy = 24'($urandom); w.lift = 24'($urandom); end
            1: begin
                w.sx = 24'($signed($urandom_range(0, 400)) - 200);
                w.sy = 24'($signed($urandom_range(0, 400)) - 200);
                w.lift = 24'($signed($urandom_range(0, 4000)) - 2000);
            end
            default: begin
                w.sx = 24'($signed($urandom_range(0, 200000)) - 100000);
                w.sy = 24'($signed($urandom_range(0, 200000)) - 100000);
                w.lift = 24'($signed($urandom_range(0, 200000)) - 100000);
            end
        endcase
        case ($urandom_range(0, 5))
            0: begin w.st = '0; w.sw = 16'($urandom_range(0, 3)); end
            1: begin w.st = 16'($urandom); w.sw = '0; end
            2: begin w.st = 16'($urandom); w.sw = 16'($urandom); end
            default: begin
                w.st = 16'($urandom_range(1, 1000));
                w.sw = 16'($urandom_range(1, 1000));
            end
        endcase
        return w;
    endfunction

    task automatic test_directed();
        step_t w;
        w = '{MODE_STAND, 16'h1234, 24'sd5000, 24'sd5000, 24'sd100, 16'd300, 16'd200};
        send_word(w);
        w.mode = MODE_RSVD; send_word(w);
        w.mode = MODE_TROT; w.sx = 24'sd99; w.sy = -24'sd99; send_word(w);
        w.sx = 24'sd100; send_word(w);
        w.sx = -24'sd100; w.sy = '0; send_word(w);
        w.sx = 24'sd5000; w.st = '0; w.sw = '0; send_word(w);
        w.st = '0; w.sw = 16'd500; w.phase = '0; send_word(w);
        w.st = 16'd500; w.sw = '0; w.phase = 16'hFFFF; send_word(w);
        w = '{MODE_TROT, 16'h0000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF,
              16'hFFFF, 16'hFFFF};
        send_word(w);
        w.phase = 16'h8000; send_word(w);
        w.phase = 16'hC000; send_word(w);
        w.phase = 16'hFFFF; send_word(w);
        w.mode = MODE_CRAWL; w.lift = 24'sh800000; w.phase = 16'hA000; send_word(w);
        w = '{MODE_CRAWL, 16'h4000, -24'sd20000, 24'sd30000, 24'sd15000, 16'd3, 16'd1};
        send_word(w);
        w.phase = 16'hE000; send_word(w);
        w.mode = MODE_TROT; send_word(w);
        drain();
    endtask

    task automatic test_config_sweep();
        write_reg(CFG_HOME_X, 24'h7FFFFF); write_reg(CFG_HOME_Y, 24'h800000);
        write_reg(CFG_HOME_Z, 24'h7FFFF0); write_reg(CFG_LIMB_OFS, 24'h00FFFF);
        write_reg(CFG_CRAWL_OFS, 24'h008000);
        repeat (100) send_word(random_step());
        drain();
        write_reg(CFG_HOME_X, 24'h800000); write_reg(CFG_HOME_Y, 24'h7FFFFF);
        write_reg(CFG_HOME_Z, 24'h800000); write_reg(CFG_LIMB_OFS, 24'h000000);
        write_reg(CFG_CRAWL_OFS, 24'hFFFFFF);
        repeat (100) send_word(random_step());
        drain();
    endtask

    task automatic test_random();
        for (int k = 0; k < 6; k++) begin
            write_reg(CFG_HOME_X, 24'($urandom_range(0, 200000) - 100000));
            write_reg(CFG_HOME_Y, 24'($urandom_range(0, 200000) - 100000));
            write_reg(CFG_HOME_Z, 24'($urandom));
            write_reg(CFG_LIMB_OFS, 24'($urandom));
            write_reg(CFG_CRAWL_OFS, 24'($urandom));
            repeat (100) send_word(random_step(), k == 2);
            drain();
        end
    endtask

    // back-to-back burst with sink always ready
    task automatic test_full_rate();
        hold_sink = 1'b1;
        repeat (30) send_word(random_step(), 1);
        drain();
        hold_sink = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_config_sweep();
        test_random();
        test_full_rate();
        $display("sent %0d words, checked %0d results over stand, trot, crawl,", words_sent,
            words_checked);
        $display("deadband, zero durations, saturation and register extremes");
        if (mismatches == 0 && expected_feet.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/gft_pkg.sv
rtl/gait_foot_trajectory_core.sv
rtl/gft_checker.sv
tb/sv/gait_foot_trajectory_core_tb.sv
